/* hdl/randomized_index_set_defines.svh */
// Assertion macros for the randomized index set checker.
`ifndef RANDOMIZED_INDEX_SET_DEFINES_SVH
`define RANDOMIZED_INDEX_SET_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define RIS_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("randomized_index_set: check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define RIS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("randomized_index_set: check failed");

`endif

/* hdl/ris_pkg.sv */
// Shared types and command codes for the randomized index set.
package ris_pkg;

    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] OP_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] OP_PICK   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clear one present bit
        logic load;       // capture item, start table reads, multiply
        logic exec;       // apply insert/remove, set success
        logic pick_rd;    // read dense table at the picked slot
        logic pick_done;  // capture picked member
        logic out_load;   // move result into the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last; // last present bit being cleared
        logic pick_go;    // pick on a non-empty set
    } dp_stat_t;

endpackage

/* hdl/ris_ctrl.sv */
// Sequencing state machine for the randomized index set.
module ris_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  ris_pkg::dp_stat_t stat,
    output ris_pkg::dp_cmd_t  cmd
);
    import ris_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_PICK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.exec = 1'b1;
                if (stat.pick_go)
                begin
                    cmd.pick_rd = 1'b1;
                    state_next  = S_PICK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PICK:
            begin
                cmd.pick_done = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* hdl/ris_dp.sv */
// Tables, member count, pick multiplier and result registers.
module ris_dp #(
    parameter int KEY_BITS      = 10,
    parameter int CAPACITY      = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ris_pkg::dp_cmd_t                cmd,
    output ris_pkg::dp_stat_t               stat,
    input  logic [ris_pkg::CMD_W-1:0]       command,
    input  logic [KEY_BITS-1:0]             key,
    input  logic [FRACTION_BITS-1:0]        random_fraction,
    output logic                            success,
    output logic [KEY_BITS-1:0]             picked_key,
    output logic [$clog2(CAPACITY+1)-1:0]   member_count
);
    import ris_pkg::*;

    localparam int KEY_SPACE = 1 << KEY_BITS;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PROD_W    = FRACTION_BITS + CNT_W;

    // tables
    logic                present_mem [KEY_SPACE];
    logic [SLOT_W-1:0]   slot_mem    [KEY_SPACE];
    logic [KEY_BITS-1:0] dense_mem   [CAPACITY];

    logic                present_rd_reg;
    logic [SLOT_W-1:0]   slot_rd_reg;
    logic [KEY_BITS-1:0] dense_rd_reg;

    logic [CMD_W-1:0]    op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [KEY_BITS-1:0] clr_addr_reg;

    logic                res_ok_reg;
    logic [KEY_BITS-1:0] res_key_reg;
    logic                success_reg;
    logic [KEY_BITS-1:0] picked_key_reg;
    logic [CNT_W-1:0]    member_count_reg;

    logic [CNT_W-1:0]    count_dec;
    logic [SLOT_W-1:0]   last_slot;
    logic [SLOT_W-1:0]   tail_slot;
    logic [SLOT_W-1:0]   hole_slot;
    logic [CNT_W-1:0]    pick_full;
    logic [SLOT_W-1:0]   pick_slot;
    logic                not_full;
    logic                not_empty;
    logic                do_insert;
    logic                do_remove;
    logic                pick_ok;

    logic                present_we;
    logic [KEY_BITS-1:0] present_wa;
    logic                present_wd;
    logic                slot_we;
    logic [KEY_BITS-1:0] slot_wa;
    logic [SLOT_W-1:0]   slot_wd;
    logic                dense_we;
    logic [SLOT_W-1:0]   dense_wa;
    logic [KEY_BITS-1:0] dense_wd;
    logic                dense_re;
    logic [SLOT_W-1:0]   dense_ra;

    assign count_dec = count_reg - CNT_W'(1);
    assign last_slot = count_dec[SLOT_W-1:0];
    assign tail_slot = count_reg[SLOT_W-1:0];
    assign not_full  = (count_reg < CNT_W'(CAPACITY));
    assign not_empty = (count_reg != '0);

    assign do_insert = cmd.exec && (op_reg == OP_INSERT) && !present_rd_reg && not_full;
    assign do_remove = cmd.exec && (op_reg == OP_REMOVE) && present_rd_reg && not_empty;
    assign pick_ok   = (op_reg == OP_PICK) && not_empty;

    // hole is clamped below the count, as is the picked slot
    assign hole_slot = (CNT_W'(slot_rd_reg) >= count_reg) ? last_slot : slot_rd_reg;
    assign pick_full = prod_reg[PROD_W-1:FRACTION_BITS];
    assign pick_slot = (pick_full >= count_reg) ? last_slot : pick_full[SLOT_W-1:0];

    assign stat.clear_last = (clr_addr_reg == {KEY_BITS{1'b1}});
    assign stat.pick_go    = pick_ok;

    always_comb
    begin
        present_we = cmd.clear || do_insert || do_remove;
        present_wa = cmd.clear ? clr_addr_reg : key_reg;
        present_wd = do_insert;

        slot_we = do_insert || do_remove;
        slot_wa = do_insert ? key_reg : dense_rd_reg;
        slot_wd = do_insert ? tail_slot : hole_slot;

        dense_we = do_insert || do_remove;
        dense_wa = do_insert ? tail_slot : hole_slot;
        dense_wd = do_insert ? key_reg : dense_rd_reg;

        dense_re = cmd.load || cmd.pick_rd;
        dense_ra = cmd.load ? last_slot : pick_slot;
    end

    always_ff @(posedge clk)
    begin
        if (present_we)
        begin
            present_mem[present_wa] <= present_wd;
        end
        if (cmd.load)
        begin
            present_rd_reg <= present_mem[key];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (cmd.load)
        begin
            slot_rd_reg <= slot_mem[key];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dense_mem[dense_wa] <= dense_wd;
        end
        if (dense_re)
        begin
            dense_rd_reg <= dense_mem[dense_ra];
        end
    end

    always_comb
    begin
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_dec;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + KEY_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= command;
            key_reg  <= key;
            prod_reg <= {{CNT_W{1'b0}}, random_fraction} * {{FRACTION_BITS{1'b0}}, count_reg};
        end
        if (cmd.exec)
        begin
            res_ok_reg  <= do_insert || do_remove || pick_ok;
            res_key_reg <= '0;
        end
        if (cmd.pick_done)
        begin
            res_key_reg <= dense_rd_reg;
        end
        if (cmd.out_load)
        begin
            success_reg      <= res_ok_reg;
            picked_key_reg   <= res_key_reg;
            member_count_reg <= count_reg;
        end
    end

    assign success      = success_reg;
    assign picked_key   = picked_key_reg;
    assign member_count = member_count_reg;

endmodule

/* hdl/randomized_index_set.sv */
// Top level of the randomized index set: controller plus datapath.
//
// Keeps a set of keys below 2^KEY_BITS with insert, remove and uniform random
// pick. Each accepted item (command, key, random_fraction) gives exactly one
// result item: success, picked_key (zero unless a pick found a member) and
// member_count after the operation. Members sit in a dense table with a
// key-to-slot table and a membership bitmap beside it; remove moves the last
// member into the freed slot. A pick takes slot
// (random_fraction * count) >> FRACTION_BITS.
// Timing: after reset the membership bitmap is cleared one key a cycle, and
// req_stall stays high until every key is cleared; only then is the first
// item taken. Then an item is handled one at a time: for insert, remove and
// failed operations the item passes through the read state to the done
// state, where the result register is loaded, and the next item can be taken
// after that; a successful pick adds a pick state between the two. The steps
// are set by the registered table reads: one read to look up the key and the
// last member, and for a pick a second read of the dense table at the slot
// the multiplier gave. A new item is taken while an earlier result still
// waits on rsp_stall; its own result then waits in the done state until the
// output register is free.
module randomized_index_set #(
    parameter int KEY_BITS      = 10,
    parameter int CAPACITY      = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [ris_pkg::CMD_W-1:0]       command,
    input  logic [KEY_BITS-1:0]             key,
    input  logic [FRACTION_BITS-1:0]        random_fraction,
    // result channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            success,
    output logic [KEY_BITS-1:0]             picked_key,
    output logic [$clog2(CAPACITY+1)-1:0]   member_count
);
    import ris_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing: clear pass, accept, read, optional pick read, result
    ris_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tables, count and result registers
    ris_dp #(
        .KEY_BITS      (KEY_BITS),
        .CAPACITY      (CAPACITY),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (command),
        .key             (key),
        .random_fraction (random_fraction),
        .success         (success),
        .picked_key      (picked_key),
        .member_count    (member_count)
    );

endmodule

/* hdl/ris_check.sv */
// Port-level checker for the randomized index set, bound to the top level.
`include "randomized_index_set_defines.svh"

module ris_check #(
    parameter int KEY_BITS = 10,
    parameter int CAPACITY = 1024
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic                          success,
    input logic [KEY_BITS-1:0]           picked_key,
    input logic [$clog2(CAPACITY+1)-1:0] member_count
);

    // stalled result holds
    `RIS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
        rsp_valid && $stable(success) && $stable(picked_key) && $stable(member_count))

    // one item in flight: an accepted item blocks the next cycle
    `RIS_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

    // count never passes capacity
    `RIS_ASSERT_NOW(a_count_bound, rsp_valid,
        member_count <= ($clog2(CAPACITY+1))'(CAPACITY))

    // failed operations report no member
    `RIS_ASSERT_NOW(a_fail_no_key, rsp_valid && !success, picked_key == '0)

endmodule

bind randomized_index_set ris_check #(
    .KEY_BITS (KEY_BITS),
    .CAPACITY (CAPACITY)
) u_ris_check (.*);

/* test/testbench.sv */
// Self-checking testbench for the randomized index set: insert, remove and random pick.
module testbench;
    import ris_pkg::*;

    localparam int KEY_BITS      = 10;
    localparam int CAPACITY      = 1024;
    localparam int FRACTION_BITS = 16;
    localparam int KEY_SPACE     = 1 << KEY_BITS;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int IDLE_PCT      = 27;

    // Command code the block does not define; it must act as a no-op.
    localparam logic [CMD_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [FRACTION_BITS-1:0] FRAC_MIN = '0;
    localparam logic [FRACTION_BITS-1:0] FRAC_MAX = '1;
    localparam logic [KEY_BITS-1:0]      KEY_MAX  = '1;

    // One result item as the block reports it.
    typedef struct packed {
        logic                success;
        logic [KEY_BITS-1:0] picked_key;
        logic [COUNT_W-1:0]  member_count;
    } set_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [CMD_W-1:0]         command;
    logic [KEY_BITS-1:0]      key;
    logic [FRACTION_BITS-1:0] random_fraction;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic                     success;
    logic [KEY_BITS-1:0]      picked_key;
    logic [COUNT_W-1:0]       member_count;

    randomized_index_set #(
        .KEY_BITS      (KEY_BITS),
        .CAPACITY      (CAPACITY),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .command         (command),
        .key             (key),
        .random_fraction (random_fraction),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .success         (success),
        .picked_key      (picked_key),
        .member_count    (member_count)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the set. Updated at the moment an item is accepted,
    // so the sender can also use it to choose keys that are really present.
    // ------------------------------------------------------------------
    logic                member_flag  [KEY_SPACE];   // key is in the set
    logic [KEY_BITS-1:0] slot_index   [KEY_SPACE];   // key -> dense slot
    logic [KEY_BITS-1:0] member_list  [CAPACITY];    // dense member array
    logic [COUNT_W-1:0]  member_total;

    // Results still owed by the block, oldest first.
    set_result_t pending_results[$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int op_tally [4];       // accepted items per command code
    int hit_tally;          // predicted successes
    int peak_members;
    int results_seen;

    always #10 clk = ~clk;

    // Apply one operation to the shadow set and return what the block must report.
    function automatic set_result_t apply_set_op(input logic [CMD_W-1:0] cmd,
                                                 input logic [KEY_BITS-1:0] k,
                                                 input logic [FRACTION_BITS-1:0] frac);
        set_result_t                      res;
        logic [KEY_BITS-1:0]              hole;
        logic [KEY_BITS-1:0]              last_key;
        logic [COUNT_W-1:0]               last_idx;
        logic [FRACTION_BITS+COUNT_W-1:0] scaled;
        res = '0;
        case (cmd)
            OP_INSERT:
            begin
                // a present key or a full set leaves everything alone
                if (!member_flag[k] && member_total < CAPACITY)
                begin
                    member_flag[k]                          = 1'b1;
                    slot_index[k]                           = member_total[KEY_BITS-1:0];
                    member_list[member_total[KEY_BITS-1:0]] = k;
                    member_total                            = member_total + 1'b1;
                    res.success                             = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                // last member moves into the freed slot
                if (member_flag[k] && member_total != 0)
                begin
                    hole                 = slot_index[k];
                    last_idx             = member_total - 1'b1;
                    last_key             = member_list[last_idx[KEY_BITS-1:0]];
                    member_list[hole]    = last_key;
                    slot_index[last_key] = hole;
                    member_total         = member_total - 1'b1;
                    member_flag[k]       = 1'b0;
                    res.success          = 1'b1;
                end
            end
            OP_PICK:
            begin
                // slot = floor(frac * count / 2^FRACTION_BITS), always below count
                if (member_total != 0)
                begin
                    scaled         = frac * member_total;
                    res.picked_key = member_list[scaled[FRACTION_BITS +: KEY_BITS]];
                    res.success    = 1'b1;
                end
            end
            default: ;
        endcase
        res.member_count = member_total;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional random gap, then hold the item until it is taken.
    // The item is predicted at acceptance, so prediction order equals
    // acceptance order.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_BITS-1:0] k,
                             input logic [FRACTION_BITS-1:0] frac);
        set_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid       <= 1'b1;
        command         <= cmd;
        key             <= k;
        random_fraction <= frac;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        res = apply_set_op(cmd, k, frac);
        pending_results = {pending_results, res};
        op_tally[cmd]++;
        if (res.success) hit_tally++;
        if (member_total > peak_members) peak_members = member_total;
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Keys mostly from a narrow window so inserts and removes collide often.
    function automatic logic [KEY_BITS-1:0] rand_key();
        if ($urandom_range(99) < 70) return KEY_BITS'($urandom_range(31));
        return KEY_BITS'($urandom_range(KEY_SPACE - 1));
    endfunction

    // Fractions with extra weight on both ends of the range.
    function automatic logic [FRACTION_BITS-1:0] rand_fraction();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return FRAC_MIN;
        if (sel == 1) return FRAC_MAX;
        return FRACTION_BITS'($urandom_range((1 << FRACTION_BITS) - 1));
    endfunction

    // A key known to be in the set; caller checks the set is not empty.
    function automatic logic [KEY_BITS-1:0] present_key();
        return member_list[KEY_BITS'($urandom_range(member_total - 1))];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner cases on a small set: empty-set pick, absent remove, duplicate
    // insert, unused command, key and fraction extremes, removal from the
    // first, middle and last slot.
    task automatic test_empty_set_corners();
        send_item(OP_PICK,   '0,           FRAC_MAX);   // pick on empty set
        send_item(OP_REMOVE, 10'd5,        FRAC_MIN);   // remove of absent key
        send_item(OP_UNUSED, KEY_MAX,      FRAC_MAX);   // undefined command, empty
        send_item(OP_INSERT, '0,           FRAC_MIN);
        send_item(OP_INSERT, KEY_MAX,      FRAC_MAX);
        send_item(OP_INSERT, '0,           FRAC_MAX);   // duplicate insert
        send_item(OP_INSERT, 10'h2AA,      FRAC_MIN);
        send_item(OP_INSERT, 10'h155,      FRAC_MIN);
        send_item(OP_PICK,   10'h3FF,      FRAC_MIN);   // first slot
        send_item(OP_PICK,   '0,           FRAC_MAX);   // last slot
        send_item(OP_PICK,   10'h155,      16'h8000);
        send_item(OP_REMOVE, 10'h2AA,      FRAC_MAX);   // middle slot
        send_item(OP_PICK,   '0,           16'h5555);
        send_item(OP_REMOVE, 10'h155,      FRAC_MIN);   // last slot
        send_item(OP_REMOVE, 10'h155,      FRAC_MIN);   // now absent
        send_item(OP_UNUSED, '0,           FRAC_MIN);   // undefined command, non-empty
        send_item(OP_REMOVE, '0,           FRAC_MIN);   // first slot
        send_item(OP_PICK,   '0,           16'hAAAA);
        send_item(OP_REMOVE, KEY_MAX,      FRAC_MAX);   // set empty again
        send_item(OP_PICK,   KEY_MAX,      FRAC_MIN);
        send_item(OP_INSERT, 10'h200,      FRAC_MAX);
        send_item(OP_PICK,   '0,           FRAC_MAX);
    endtask

    // Mixed random traffic on a small, churning set.
    task automatic test_random_mix(input int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(99);
            if (sel < 35)
                send_item(OP_INSERT, rand_key(), rand_fraction());
            else if (sel < 55 && member_total != 0)
                send_item(OP_REMOVE, present_key(), rand_fraction());
            else if (sel < 65)
                send_item(OP_REMOVE, rand_key(), rand_fraction());
            else if (sel < 95)
                send_item(OP_PICK, rand_key(), rand_fraction());
            else
                send_item(OP_UNUSED, rand_key(), rand_fraction());
        end
    endtask

    // Insert every key in shuffled order until the set is full, with picks
    // and duplicate inserts mixed in; then hit the full set. The first part
    // runs with both sides streaming back to back.
    task automatic test_fill_to_capacity();
        logic [KEY_BITS-1:0] order [KEY_SPACE];
        logic [KEY_BITS-1:0] tmp;
        int                  j;
        for (int i = 0; i < KEY_SPACE; i++) order[KEY_BITS'(i)] = KEY_BITS'(i);
        for (int i = KEY_SPACE - 1; i > 0; i--)
        begin
            j                   = $urandom_range(i);
            tmp                 = order[KEY_BITS'(i)];
            order[KEY_BITS'(i)] = order[KEY_BITS'(j)];
            order[KEY_BITS'(j)] = tmp;
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < KEY_SPACE; i++)
        begin
            if (i == 400)
            begin
                send_idle_pct = IDLE_PCT;
                recv_idle_pct = IDLE_PCT;
            end
            if (!member_flag[order[KEY_BITS'(i)]])
                send_item(OP_INSERT, order[KEY_BITS'(i)], rand_fraction());
            if ($urandom_range(5) == 0)
                send_item(OP_PICK, rand_key(), rand_fraction());
            if ($urandom_range(19) == 0 && member_total != 0)
                send_item(OP_INSERT, present_key(), rand_fraction());
        end
        // set is full: inserts must be refused, picks span the whole array
        send_item(OP_INSERT, rand_key(), FRAC_MAX);
        send_item(OP_INSERT, KEY_MAX,    FRAC_MIN);
        send_item(OP_PICK,   '0,         FRAC_MIN);
        send_item(OP_PICK,   KEY_MAX,    FRAC_MAX);
        send_item(OP_UNUSED, KEY_MAX,    FRAC_MAX);
        repeat (5) send_item(OP_PICK, rand_key(), rand_fraction());
    endtask

    // Remove-heavy traffic that shrinks the full set.
    task automatic test_drain(input int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(99);
            if (sel < 60 && member_total != 0)
                send_item(OP_REMOVE, present_key(), rand_fraction());
            else if (sel < 75)
                send_item(OP_REMOVE, KEY_BITS'($urandom_range(KEY_SPACE - 1)), rand_fraction());
            else if (sel < 90)
                send_item(OP_PICK, rand_key(), rand_fraction());
            else if (sel < 97)
                send_item(OP_INSERT, KEY_BITS'($urandom_range(KEY_SPACE - 1)), rand_fraction());
            else
                send_item(OP_UNUSED, rand_key(), rand_fraction());
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, and a field-by-field check of every
    // accepted result against the oldest owed one. Values are read at the
    // edge, before any update of that edge lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        set_result_t exp_res;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: success %0d picked_key %0d member_count %0d",
                       success, picked_key, member_count);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (success !== exp_res.success)
                begin
                    $error("success: expected %0d, got %0d", exp_res.success, success);
                    error_count++;
                end
                if (picked_key !== exp_res.picked_key)
                begin
                    $error("picked_key: expected %0d, got %0d", exp_res.picked_key, picked_key);
                    error_count++;
                end
                if (member_count !== exp_res.member_count)
                begin
                    $error("member_count: expected %0d, got %0d",
                           exp_res.member_count, member_count);
                    error_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Main sequence. The block clears its bitmap after reset; the first send
    // simply waits on req_stall.
    // ------------------------------------------------------------------
    initial
    begin
        clk             = 1'b0;
        error_count     = 0;
        hit_tally       = 0;
        peak_members    = 0;
        results_seen    = 0;
        send_idle_pct   = IDLE_PCT;
        recv_idle_pct   = IDLE_PCT;
        member_total    = '0;
        foreach (op_tally[i]) op_tally[i] = 0;
        foreach (member_flag[i]) member_flag[i] = 1'b0;
        rst_n           <= 1'b0;
        req_valid       <= 1'b0;
        command         <= OP_INSERT;
        key             <= '0;
        random_fraction <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set_corners();
        wait_drained();             // sender holds off until all results are back
        test_random_mix(350);
        wait_drained();
        test_fill_to_capacity();
        wait_drained();
        test_drain(300);
        wait_drained();
        repeat (8) @(posedge clk);  // catch any stray late result

        $display("covered %0d inserts, %0d removes, %0d picks, %0d undefined commands",
                 op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_PICK],
                 op_tally[OP_UNUSED]);
        $display("%0d operations succeeded, set grew to %0d members, %0d results checked",
                 hit_tally, peak_members, results_seen);
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (about 1900 items, bitmap
    // clear, stalls on both sides).
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/ris_pkg.sv
hdl/ris_ctrl.sv
hdl/ris_dp.sv
hdl/randomized_index_set.sv
hdl/ris_check.sv
test/testbench.sv
